FILE: sv/pct_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the pausable countdown timer.
package pct_pkg;

	// Field widths
	localparam int OPCODE_W = 2;
	localparam int ELAPSED_W = 16;
	localparam int TURN_W = 8;
	localparam int ACTION_W = 8;
	localparam int STATE_W = 2;
	localparam int MIN_W = 7;
	localparam int SEC_W = 6;
	localparam int MS_W = 23;
	localparam int SECS_W = 13;

	// Time constants
	localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
	localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
	localparam logic [MIN_W-1:0] MINUTES_MIN = 7'd1;
	localparam logic [MIN_W-1:0] MINUTES_MAX = 7'd99;
	localparam logic [MIN_W-1:0] MINUTES_AT_RESET = 7'd25;

	// Reciprocal multipliers: floor(x/1000) for x < 2**23, floor(x/60) for x < 2**13
	localparam int DIV1000_PROD_W = 47;
	localparam logic [23:0] DIV1000_MUL = 24'd8589935;
	localparam int DIV1000_SHIFT = 33;
	localparam int DIV60_PROD_W = 28;
	localparam logic [14:0] DIV60_MUL = 15'd17477;
	localparam int DIV60_SHIFT = 20;

	// Event kinds
	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK    = 2'd0,
		OP_TURN    = 2'd1,
		OP_CONFIRM = 2'd2,
		OP_SELECT  = 2'd3
	} opcode_t;

	// Timer modes
	typedef enum logic [STATE_W-1:0] {
		MODE_IDLE  = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_PAUSE = 2'd2,
		MODE_DONE  = 2'd3
	} mode_t;

	// Select action codes
	localparam logic [ACTION_W-1:0] ACT_RESET = 8'd0;
	localparam logic [ACTION_W-1:0] ACT_START = 8'd1;
	localparam logic [ACTION_W-1:0] ACT_PAUSE = 8'd2;
	localparam logic [ACTION_W-1:0] ACT_RESUME = 8'd3;

	// Updated timer state for one event, passed to the display stages
	typedef struct packed {
		logic valid;
		mode_t mode;
		logic [MIN_W-1:0] set_minutes;
		logic [MS_W-1:0] remaining_ms;
		logic finished;
		logic accepted;
	} upd_beat_t;

	localparam logic [MS_W-1:0] MS_AT_RESET = 23'd1500000;

	// Whole minutes to milliseconds (constant multiply, at most 99 minutes)
	function automatic logic [MS_W-1:0] minutes_to_ms(input logic [MIN_W-1:0] m);
		return MS_W'(m) * MS_W'(MS_PER_MINUTE);
	endfunction

endpackage

FILE: sv/pct_evt_if.sv
`timescale 1ns / 1ps
// Event channel: valid/ready handshake with the event fields.
interface pct_evt_if;
	import pct_pkg::*;

	logic valid;
	logic ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ELAPSED_W-1:0] elapsed_ms;
	logic signed [TURN_W-1:0] turn_steps;
	logic [ACTION_W-1:0] action_index;

	modport source(output valid, opcode, elapsed_ms, turn_steps, action_index, input ready);
	modport sink(input valid, opcode, elapsed_ms, turn_steps, action_index, output ready);
endinterface

FILE: sv/pct_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the displayed timer fields.
interface pct_res_if;
	import pct_pkg::*;

	logic valid;
	logic ready;
	logic [STATE_W-1:0] timer_state;
	logic [MIN_W-1:0] shown_minutes;
	logic [SEC_W-1:0] shown_seconds;
	logic finished;
	logic accepted;

	modport source(output valid, timer_state, shown_minutes, shown_seconds, finished, accepted,
		input ready);
	modport sink(input valid, timer_state, shown_minutes, shown_seconds, finished, accepted,
		output ready);
endinterface

FILE: sv/pausable_countdown_timer_core.sv
`timescale 1ns / 1ps
// An event beat passes the input register, s2, s3 and s4 before the result register.
// Throughput: one event per cycle when not stalled; the timer state updates as the
// event leaves the input register, and the mm:ss split runs in three more stages.
// Reset (arst_n low): mode idle, 25 set minutes, 1500000 ms remaining, pipeline empty.
// Stalls on the result side back up stage by stage; no beat is dropped.
module pausable_countdown_timer_core (
	input  logic      clk,
	input  logic      arst_n,
	pct_evt_if.sink   evt,
	pct_res_if.source res
);
	import pct_pkg::*;

	upd_beat_t s2;
	logic s2_ready;

	// Event decode and timer state
	pct_update u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.s2       (s2),
		.s2_ready (s2_ready)
	);

	// Display conversion and result register
	pct_display u_display (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2       (s2),
		.s2_ready (s2_ready),
		.res      (res)
	);

	// A finishing tick always lands in done with a zero display
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.finished |->
			res.timer_state == MODE_DONE && res.shown_minutes == '0 && res.shown_seconds == '0)
		else $error("finished result not in done at 00:00");

	// Displayed time stays within 99:59
	a_display_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.shown_minutes <= MINUTES_MAX && res.shown_seconds < SECONDS_PER_MINUTE)
		else $error("displayed time out of range");

	// Set minutes leaving the update stage are always clamped
	a_set_range: assert property (@(posedge clk) disable iff (!arst_n)
		s2.valid |-> s2.set_minutes >= MINUTES_MIN && s2.set_minutes <= MINUTES_MAX)
		else $error("set minutes outside 1..99");

	// A refused select never finishes the countdown
	a_refused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s2.valid && !s2.accepted |-> !s2.finished)
		else $error("refused event flagged finished");

endmodule

FILE: sv/pct_update.sv
`timescale 1ns / 1ps
// Event input register, timer state registers and the combinational state update.
module pct_update (
	input  logic               clk,
	input  logic               arst_n,
	pct_evt_if.sink            evt,
	output pct_pkg::upd_beat_t s2,
	input  logic               s2_ready
);
	import pct_pkg::*;

	// Input stage
	logic valid_s1;
	opcode_t opcode_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic signed [TURN_W-1:0] turn_s1;
	logic [ACTION_W-1:0] action_s1;

	// Timer state
	mode_t mode_q;
	logic [MIN_W-1:0] set_min_q;
	logic [MS_W-1:0] rem_q;

	// Update result stage
	logic valid_s2;
	mode_t mode_s2;
	logic [MIN_W-1:0] set_min_s2;
	logic [MS_W-1:0] rem_s2;
	logic fin_s2;
	logic acc_s2;

	// Next state
	mode_t mode_d;
	logic [MIN_W-1:0] set_min_d;
	logic [MS_W-1:0] rem_d;
	logic fin_d;
	logic acc_d;
	logic signed [MIN_W+1:0] turn_sum;
	logic [MIN_W-1:0] turn_min;
	logic [MS_W-1:0] reload_ms;

	logic adv_s2;
	logic fire_s1;

	// Handshake: s2 loads when empty or drained
	assign adv_s2 = !valid_s2 || s2_ready;
	assign fire_s1 = valid_s1 && adv_s2;
	assign evt.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			opcode_s1 <= opcode_t'(evt.opcode);
			elapsed_s1 <= evt.elapsed_ms;
			turn_s1 <= evt.turn_steps;
			action_s1 <= evt.action_index;
		end
	end

	// Knob adjustment with clamp to the legal minute range
	always_comb begin
		turn_sum = $signed({2'b00, set_min_q}) + $signed({turn_s1[TURN_W-1], turn_s1});
		if (turn_sum < $signed({2'b00, MINUTES_MIN})) begin
			turn_min = MINUTES_MIN;
		end else if (turn_sum > $signed({2'b00, MINUTES_MAX})) begin
			turn_min = MINUTES_MAX;
		end else begin
			turn_min = turn_sum[MIN_W-1:0];
		end
	end

	assign reload_ms = minutes_to_ms(set_min_q);

	// Event decode and mode transitions
	always_comb begin
		mode_d = mode_q;
		set_min_d = set_min_q;
		rem_d = rem_q;
		fin_d = 1'b0;
		acc_d = 1'b1;
		unique case (opcode_s1)
			OP_TICK: begin
				if (mode_q == MODE_RUN && elapsed_s1 != '0) begin
					if (rem_q > MS_W'(elapsed_s1)) begin
						rem_d = rem_q - MS_W'(elapsed_s1);
					end else begin
						rem_d = '0;
						mode_d = MODE_DONE;
						fin_d = 1'b1;
					end
				end
			end
			OP_TURN: begin
				if (mode_q != MODE_DONE) begin
					set_min_d = turn_min;
					rem_d = minutes_to_ms(turn_min);
				end
			end
			OP_CONFIRM: begin
				unique case (mode_q)
					MODE_IDLE: begin
						mode_d = MODE_RUN;
						if (rem_q == '0) rem_d = reload_ms;
					end
					MODE_RUN: mode_d = MODE_PAUSE;
					MODE_PAUSE: mode_d = MODE_RUN;
					MODE_DONE: begin
						mode_d = MODE_IDLE;
						rem_d = reload_ms;
					end
				endcase
			end
			OP_SELECT: begin
				unique case (action_s1)
					ACT_RESET: begin
						mode_d = MODE_IDLE;
						rem_d = reload_ms;
					end
					ACT_START: begin
						mode_d = MODE_RUN;
						if (rem_q == '0) rem_d = reload_ms;
					end
					ACT_PAUSE: mode_d = MODE_PAUSE;
					ACT_RESUME: mode_d = MODE_RUN;
					default: acc_d = 1'b0;
				endcase
			end
		endcase
	end

	// State registers commit as the event leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			set_min_q <= MINUTES_AT_RESET;
			rem_q <= MS_AT_RESET;
		end else if (fire_s1) begin
			mode_q <= mode_d;
			set_min_q <= set_min_d;
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			mode_s2 <= mode_d;
			set_min_s2 <= set_min_d;
			rem_s2 <= rem_d;
			fin_s2 <= fin_d;
			acc_s2 <= acc_d;
		end
	end

	always_comb begin
		s2.valid = valid_s2;
		s2.mode = mode_s2;
		s2.set_minutes = set_min_s2;
		s2.remaining_ms = rem_s2;
		s2.finished = fin_s2;
		s2.accepted = acc_s2;
	end

endmodule

FILE: sv/pct_display.sv
`timescale 1ns / 1ps
// Display pipeline: milliseconds to seconds, seconds to mm:ss, result register.
module pct_display (
	input  logic               clk,
	input  logic               arst_n,
	input  pct_pkg::upd_beat_t s2,
	output logic               s2_ready,
	pct_res_if.source          res
);
	import pct_pkg::*;

	// Seconds stage
	logic valid_s3;
	mode_t mode_s3;
	logic fin_s3;
	logic acc_s3;
	logic [SECS_W-1:0] secs_s3;

	// Minutes stage
	logic valid_s4;
	mode_t mode_s4;
	logic fin_s4;
	logic acc_s4;
	logic [SECS_W-1:0] secs_s4;
	logic [MIN_W-1:0] min_s4;

	// Result register
	logic out_valid_q;
	logic [STATE_W-1:0] state_q;
	logic [MIN_W-1:0] min_q;
	logic [SEC_W-1:0] sec_q;
	logic fin_q;
	logic acc_q;

	logic [DIV1000_PROD_W-1:0] ms_prod;
	logic [SECS_W-1:0] secs_d;
	logic [DIV60_PROD_W-1:0] sec_prod;
	logic [SECS_W-1:0] min_secs;
	logic adv_out;
	logic adv_s4;
	logic adv_s3;

	// Ready chain: each stage loads when empty or draining
	assign adv_out = !out_valid_q || res.ready;
	assign adv_s4 = !valid_s4 || adv_out;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign s2_ready = adv_s3;

	// Seconds shown: set time in idle, zero in done, remaining otherwise
	assign ms_prod = DIV1000_PROD_W'(s2.remaining_ms) * DIV1000_PROD_W'(DIV1000_MUL);
	always_comb begin
		case (s2.mode)
			MODE_IDLE: secs_d = SECS_W'(s2.set_minutes) * SECS_W'(SECONDS_PER_MINUTE);
			MODE_DONE: secs_d = '0;
			default:   secs_d = SECS_W'(ms_prod >> DIV1000_SHIFT);
		endcase
	end

	// Minutes by reciprocal multiply
	assign sec_prod = DIV60_PROD_W'(secs_s3) * DIV60_PROD_W'(DIV60_MUL);
	// Whole minutes back in seconds, for the remainder
	assign min_secs = SECS_W'(min_s4) * SECS_W'(SECONDS_PER_MINUTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s3) valid_s3 <= s2.valid;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_out) out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && s2.valid) begin
			mode_s3 <= s2.mode;
			fin_s3 <= s2.finished;
			acc_s3 <= s2.accepted;
			secs_s3 <= secs_d;
		end
		if (adv_s4 && valid_s3) begin
			mode_s4 <= mode_s3;
			fin_s4 <= fin_s3;
			acc_s4 <= acc_s3;
			secs_s4 <= secs_s3;
			min_s4 <= MIN_W'(sec_prod >> DIV60_SHIFT);
		end
		if (adv_out && valid_s4) begin
			state_q <= mode_s4;
			min_q <= min_s4;
			sec_q <= SEC_W'(secs_s4 - min_secs);
			fin_q <= fin_s4;
			acc_q <= acc_s4;
		end
	end

	assign res.valid = out_valid_q;
	assign res.timer_state = state_q;
	assign res.shown_minutes = min_q;
	assign res.shown_seconds = sec_q;
	assign res.finished = fin_q;
	assign res.accepted = acc_q;

endmodule
